>>> hdl/adamax_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adamax_pkg
// Shared types and constants of the adamax parameter update block:
// configuration register indices and fixed field widths.
// ----------------------------------------------------------------------------
package adamax_pkg;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_STEP_SIZE   = 2'd0;
    localparam cfg_idx_t CFG_FIRST_DECAY = 2'd1;
    localparam cfg_idx_t CFG_NORM_DECAY  = 2'd2;
    localparam cfg_idx_t CFG_STABILIZER  = 2'd3;

    localparam logic [16:0] STEP_SIZE_RST   = 17'd66;
    localparam logic [15:0] FIRST_DECAY_RST = 16'd58982;
    localparam logic [15:0] NORM_DECAY_RST  = 16'd65470;
    localparam logic [16:0] STABILIZER_RST  = 17'd1;

    // number of restoring divider stages, one quotient bit each
    localparam int DIV_STAGES = 32;

endpackage
`default_nettype wire

>>> hdl/adamax_param_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adamax_param_update
// Adamax optimiser step per gradient word: first moment and infinity norm
// kept per parameter in two rams with registered reads, update from a pipelined divider.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  s_       | s_valid s_ready s_param_index s_gradient  | in
//  m_       | m_valid m_ready m_update_value            | out
//  cfg_     | cfg_wr_en cfg_index cfg_wr_data           | in
//
//  one word per cycle unless stalled; stages: ram read, product and moment
//  stages, two numerator/denominator stages, 32 divider stages, output buffer
//  a word whose index equals that of the word held in stage a waits, as the
//  moment read-modify-write loop spans stages a and b
//  after reset the rams are swept to zero with s_ready low
//  a two-word output buffer parts the sides; the pipe stalls only when it is full
module adamax_param_update #(
    parameter int PARAM_DEPTH = 1024
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [adamax_pkg::IDX_W-1:0] s_param_index,
    input  wire  signed [adamax_pkg::VAL_W-1:0] s_gradient,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [adamax_pkg::VAL_W-1:0] m_update_value,
    input  wire                          cfg_wr_en,
    input  wire  [adamax_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [adamax_pkg::CFG_W-1:0] cfg_wr_data
);
    import adamax_pkg::*;

    localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
    localparam int NS = DIV_STAGES;

    // configuration
    logic [16:0] step_size_reg;
    logic [15:0] first_decay_reg;
    logic [15:0] norm_decay_reg;
    logic [16:0] stabilizer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg   <= STEP_SIZE_RST;
            first_decay_reg <= FIRST_DECAY_RST;
            norm_decay_reg  <= NORM_DECAY_RST;
            stabilizer_reg  <= STABILIZER_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP_SIZE:   step_size_reg   <= cfg_wr_data;
                CFG_FIRST_DECAY: first_decay_reg <= cfg_wr_data[15:0];
                CFG_NORM_DECAY:  norm_decay_reg  <= cfg_wr_data[15:0];
                CFG_STABILIZER:  stabilizer_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [16:0] one_minus_b1;
    assign one_minus_b1 = 17'd65536 - {1'b0, first_decay_reg};

    // clearing pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(PARAM_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // output buffer, two words
    logic [VAL_W-1:0] obuf_reg [2];
    logic             ob_wp_reg;
    logic             ob_rp_reg;
    logic [1:0]       ob_cnt_reg;
    logic             en;
    logic             push;
    logic             pop;
    logic [VAL_W-1:0] res_word;

    assign en  = (ob_cnt_reg != 2'd2) || m_ready;
    assign pop = m_valid && m_ready;

    // stage a: after accept, ram data
    logic             a_vld_reg;
    logic             a_oor_reg;
    logic [IDX_W-1:0] a_idx_reg;
    logic signed [VAL_W-1:0] a_g_reg;
    logic signed [VAL_W-1:0] m_rd_reg;
    logic [VAL_W-1:0] u_rd_reg;

    // stage b: products
    logic             b_vld_reg;
    logic             b_oor_reg;
    logic [IDX_W-1:0] b_idx_reg;
    logic signed [48:0] b_pm_reg;
    logic signed [49:0] b_pg_reg;
    logic [47:0]      b_pu_reg;
    logic [VAL_W-1:0] b_gabs_reg;

    // stage c: new moments, also the forwarding source
    logic             c_vld_reg;
    logic             c_oor_reg;
    logic [IDX_W-1:0] c_idx_reg;
    logic signed [VAL_W-1:0] c_m_reg;
    logic [VAL_W-1:0] c_u_reg;

    // stage d
    logic             d_vld_reg;
    logic             d_oor_reg;
    logic             d_neg_reg;
    logic [48:0]      d_numa_reg;
    logic [32:0]      d_uplus_reg;

    // stage e
    logic             e_vld_reg;
    logic             e_oor_reg;
    logic             e_neg_reg;
    logic [63:0]      e_num_reg;
    logic [49:0]      e_den_reg;

    logic s_accept;
    logic s_oor;
    assign s_oor    = 32'(s_param_index) >= PARAM_DEPTH;
    assign s_ready  = en && !clr_busy_reg && !(a_vld_reg && (a_idx_reg == s_param_index));
    assign s_accept = s_valid && s_ready;

    // moment rams
    logic signed [VAL_W-1:0] m_mem [PARAM_DEPTH];
    logic [VAL_W-1:0]        u_mem [PARAM_DEPTH];
    logic                    mem_we;
    logic [AW-1:0]           mem_wa;
    logic signed [VAL_W-1:0] m_new;
    logic [VAL_W-1:0]        u_new;
    logic signed [50:0]      m_sum;
    logic [VAL_W-1:0]        u_dec;

    assign m_sum = 51'(b_pm_reg) + 51'(b_pg_reg) + 51'sd32768;
    assign m_new = m_sum[47:16];
    assign u_dec = b_pu_reg[47:16];
    assign u_new = (u_dec > b_gabs_reg) ? u_dec : b_gabs_reg;

    assign mem_we = clr_busy_reg || (en && b_vld_reg && !b_oor_reg);
    assign mem_wa = clr_busy_reg ? clr_cnt_reg : AW'(b_idx_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            m_mem[mem_wa] <= clr_busy_reg ? '0 : m_new;
            u_mem[mem_wa] <= clr_busy_reg ? '0 : u_new;
        end
        if (en) begin
            m_rd_reg <= m_mem[AW'(s_param_index)];
            u_rd_reg <= u_mem[AW'(s_param_index)];
        end
    end

    // stage a logic: forward the word written in the same cycle as our read
    logic                    fwd_hit;
    logic signed [VAL_W-1:0] m_cur;
    logic [VAL_W-1:0]        u_cur;
    assign fwd_hit = c_vld_reg && !c_oor_reg && (c_idx_reg == a_idx_reg);
    assign m_cur   = fwd_hit ? c_m_reg : m_rd_reg;
    assign u_cur   = fwd_hit ? c_u_reg : u_rd_reg;

    // stage c logic
    logic [VAL_W-1:0] c_mag;
    assign c_mag = c_m_reg[VAL_W-1] ? VAL_W'(0 - c_m_reg) : c_m_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_oor_reg <= s_oor;
            a_idx_reg <= s_param_index;
            a_g_reg   <= s_gradient;

            b_oor_reg  <= a_oor_reg;
            b_idx_reg  <= a_idx_reg;
            b_pm_reg   <= $signed({1'b0, first_decay_reg}) * m_cur;
            b_pg_reg   <= $signed({1'b0, one_minus_b1}) * a_g_reg;
            b_pu_reg   <= norm_decay_reg * u_cur;
            b_gabs_reg <= a_g_reg[VAL_W-1] ? VAL_W'(0 - a_g_reg) : a_g_reg;

            c_oor_reg <= b_oor_reg;
            c_idx_reg <= b_idx_reg;
            c_m_reg   <= m_new;
            c_u_reg   <= u_new;

            d_oor_reg   <= c_oor_reg;
            d_neg_reg   <= !c_m_reg[VAL_W-1] && (c_m_reg != '0);
            d_numa_reg  <= step_size_reg * c_mag;
            d_uplus_reg <= {1'b0, c_u_reg} + {16'b0, stabilizer_reg};

            e_oor_reg <= d_oor_reg;
            e_neg_reg <= d_neg_reg;
            e_num_reg <= {d_numa_reg[47:0], 16'b0};
            e_den_reg <= {17'b0, d_uplus_reg} * {33'b0, one_minus_b1};
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    logic             dv_vld_reg [NS+1];
    logic             dv_oor_reg [NS+1];
    logic             dv_neg_reg [NS+1];
    logic             dv_sat_reg [NS+1];
    logic [63:0]      dv_r_reg   [NS+1];
    logic [49:0]      dv_d_reg   [NS+1];
    logic [NS-1:0]    dv_q_reg   [NS+1];

    logic e_sat;
    // nonzero numerator with quotient reaching 2^32 or a zero denominator: saturate
    assign e_sat = (e_num_reg != '0) &&
                   ((e_den_reg == '0) || ({18'b0, e_num_reg[63:32]} >= e_den_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) begin
                dv_vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            dv_vld_reg[0] <= e_vld_reg;
            for (int k = 0; k < NS; k++) begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_oor_reg[0] <= e_oor_reg;
            dv_neg_reg[0] <= e_neg_reg;
            dv_sat_reg[0] <= e_sat;
            dv_r_reg[0]   <= e_num_reg;
            // zero divisor runs as one so a zero numerator gives zero
            dv_d_reg[0]   <= (e_den_reg == '0) ? 50'd1 : e_den_reg;
            dv_q_reg[0]   <= '0;
            for (int k = 0; k < NS; k++) begin
                logic [80:0] trial;
                trial = {17'b0, dv_r_reg[k]} - ({31'b0, dv_d_reg[k]} << (NS - 1 - k));
                dv_oor_reg[k+1] <= dv_oor_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_sat_reg[k+1] <= dv_sat_reg[k];
                dv_d_reg[k+1]   <= dv_d_reg[k];
                if (!trial[80]) begin
                    dv_r_reg[k+1] <= trial[63:0];
                    dv_q_reg[k+1] <= dv_q_reg[k] | (NS'(1) << (NS - 1 - k));
                end else begin
                    dv_r_reg[k+1] <= dv_r_reg[k];
                    dv_q_reg[k+1] <= dv_q_reg[k];
                end
            end
        end
    end

    // saturation and sign
    logic [VAL_W-1:0] lim;
    logic [VAL_W-1:0] q_sat;
    assign lim   = dv_neg_reg[NS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign q_sat = (dv_sat_reg[NS] || (dv_q_reg[NS] > lim)) ? lim : dv_q_reg[NS];
    assign res_word = dv_oor_reg[NS] ? '0 :
                      (dv_neg_reg[NS] ? VAL_W'(0 - q_sat) : q_sat);
    assign push = en && dv_vld_reg[NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_wp_reg  <= 1'b0;
            ob_rp_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                ob_wp_reg <= !ob_wp_reg;
            end
            if (pop) begin
                ob_rp_reg <= !ob_rp_reg;
            end
            ob_cnt_reg <= ob_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            obuf_reg[ob_wp_reg] <= res_word;
        end
    end

    assign m_valid        = ob_cnt_reg != 2'd0;
    assign m_update_value = obuf_reg[ob_rp_reg];

endmodule
`default_nettype wire
